// ===== rtl/s2i_pkg.sv =====
// shared types, character constants and helpers for the string to integer parser
`default_nettype none

package s2i_pkg;

	// width of the end offset field and the character counters
	localparam int OFFSET_BITS = 16;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [5:0] BASE_AUTO = 6'd0;
	localparam logic [5:0] BASE_ONE  = 6'd1;
	localparam logic [5:0] BASE_OCT  = 6'd8;
	localparam logic [5:0] BASE_DEC  = 6'd10;
	localparam logic [5:0] BASE_HEX  = 6'd16;
	localparam logic [5:0] MAX_RADIX = 6'd36;

	localparam logic [6:0] NOT_DIGIT = 7'd99;
	localparam logic [6:0] LETTER_BIAS = 7'd10;

	// input item: one character
	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
	} char_item_t;

	// result item: one parsed number
	typedef struct packed {
		logic signed [63:0]      value;
		logic [OFFSET_BITS-1:0]  end_offset;
		logic                    formed;
	} res_item_t;

	// parse phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SIGNED,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS
	} phase_t;

	// architectural parse state carried from one character to the next
	typedef struct packed {
		phase_t                 phase;
		logic [63:0]            acc;
		logic                   neg;
		logic [5:0]             base;
		logic [OFFSET_BITS-1:0] count;
		logic [OFFSET_BITS-1:0] pend;
	} parse_state_t;

	// digit value of a character, NOT_DIGIT when it is not alphanumeric
	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [6:0] d;
		d = NOT_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = 7'(c - CH_ZERO);
		end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
			d = 7'(c - CH_LC_A) + LETTER_BIAS;
		end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
			d = 7'(c - CH_UC_A) + LETTER_BIAS;
		end
		return d;
	endfunction

	// space, tab, line feed, vertical tab, form feed, carriage return
	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// saturating increment of an offset counter
	function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/s2i_step.sv =====
// next-state and result logic for one character of the parse
`default_nettype none

module s2i_step (
	input  s2i_pkg::parse_state_t cur,
	input  s2i_pkg::char_item_t   item,
	input  logic [5:0]            number_base,
	output s2i_pkg::parse_state_t nxt,
	output logic                  emit,
	output s2i_pkg::res_item_t    result
);
	import s2i_pkg::*;

	// build a result from the sign and accumulator in force
	function automatic res_item_t make_result(input logic neg, input logic [63:0] acc,
			input logic formed, input logic [OFFSET_BITS-1:0] offset);
		res_item_t r;
		r.formed     = formed;
		r.value      = formed ? (neg ? 64'(-acc) : acc) : '0;
		r.end_offset = formed ? offset : '0;
		return r;
	endfunction

	// one parse step
	always_comb begin
		parse_state_t           st;
		logic                   done;
		logic [OFFSET_BITS-1:0] idx;
		logic [6:0]             d;
		logic [5:0]             fb;
		st     = cur;
		done   = 1'b0;
		emit   = 1'b0;
		result = '0;
		idx    = cur.count;
		d      = digit_of(item.ch);
		fb     = cur.base;

		// start of a new string drops any parse in progress
		if (item.start_req) begin
			st.phase = PH_LEAD;
			st.acc   = '0;
			st.neg   = 1'b0;
			st.count = '0;
			st.pend  = '0;
			st.base  = number_base;
			if (number_base == BASE_ONE || number_base > MAX_RADIX) begin
				emit     = 1'b1;
				result   = make_result(1'b0, '0, 1'b0, '0);
				st.phase = PH_IDLE;
				done     = 1'b1;
			end
		end

		if (!done && st.phase != PH_IDLE) begin
			idx      = st.count;
			st.count = sat_inc(st.count);
			unique case (st.phase)
				PH_LEAD, PH_SIGNED: begin
					if (st.phase == PH_LEAD && is_space(item.ch)) begin
						// skip leading whitespace
					end else if (st.phase == PH_LEAD &&
							(item.ch == CH_MINUS || item.ch == CH_PLUS)) begin
						st.neg   = (item.ch == CH_MINUS);
						st.phase = PH_SIGNED;
					end else if (item.ch == CH_ZERO &&
							(st.base == BASE_AUTO || st.base == BASE_HEX)) begin
						// possible radix prefix
						st.acc   = '0;
						st.pend  = sat_inc(idx);
						st.phase = PH_ZERO;
					end else begin
						fb      = (st.base == BASE_AUTO) ? BASE_DEC : st.base;
						st.base = fb;
						if (d < {1'b0, fb}) begin
							st.acc   = 64'(d);
							st.phase = PH_DIGITS;
						end else begin
							emit     = 1'b1;
							result   = make_result(st.neg, st.acc, 1'b0, '0);
							st.phase = PH_IDLE;
						end
					end
				end
				PH_ZERO: begin
					if (item.ch == CH_LC_X || item.ch == CH_UC_X) begin
						st.base  = BASE_HEX;
						st.phase = PH_PREFIX;
					end else begin
						fb      = (st.base == BASE_AUTO) ? BASE_OCT : st.base;
						st.base = fb;
						if (d < {1'b0, fb}) begin
							st.acc   = 64'(d);
							st.phase = PH_DIGITS;
						end else begin
							emit     = 1'b1;
							result   = make_result(st.neg, st.acc, 1'b1, idx);
							st.phase = PH_IDLE;
						end
					end
				end
				PH_PREFIX: begin
					// prefix counts only when a hex digit follows
					if (d < {1'b0, BASE_HEX}) begin
						st.acc   = 64'(d);
						st.phase = PH_DIGITS;
					end else begin
						emit     = 1'b1;
						result   = make_result(st.neg, st.acc, 1'b1, st.pend);
						st.phase = PH_IDLE;
					end
				end
				PH_DIGITS: begin
					// multiply-accumulate by the radix, wrapping at 64 bits
					if (d < {1'b0, st.base}) begin
						st.acc = st.acc * 64'(st.base) + 64'(d);
					end else begin
						emit     = 1'b1;
						result   = make_result(st.neg, st.acc, 1'b1, idx);
						st.phase = PH_IDLE;
					end
				end
				default: begin
					st.phase = PH_IDLE;
				end
			endcase
		end
		nxt = st;
	end

endmodule

`default_nettype wire

// ===== rtl/string_to_integer_parser_core.sv =====
// top level of the streaming string to integer parser
// Usage:
// Characters enter on the char channel (char_valid, char_stall, char_item), one per
// item; start_req marks the first character of a string and NUL ends it. At most one
// result per string leaves on the res channel (res_valid, res_stall, res_item)
// with the parsed value, the end offset and the formed flag. The radix is
// written on the cfg channel (cfg_valid, cfg_ready, cfg_data) while no string is
// in flight; cfg_ready is always high and the radix is latched at each start.
// Path: an accepted character is registered in the input register and parsed
// from there, and a result it produces is then registered in the result register.
// Throughput: one character per cycle while char_stall is low; the input register
// and the result register each hold one item and the parse step is combinational.
// Stall: a held result stays on res_item; the parser keeps taking characters
// that produce no result, and holds off (char_stall) only when the waiting
// character would produce a result while the held result is still stalled.
// Reset: arst_n clears the parse to idle, the radix to automatic and both
// valid flags; characters before the first start are ignored.
`default_nettype none

module string_to_integer_parser_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  s2i_pkg::char_item_t  char_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output s2i_pkg::res_item_t   res_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [5:0]           cfg_data
);
	import s2i_pkg::*;

	char_item_t   char_s1;
	logic         valid_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic [5:0]   base_q;
	res_item_t    res_q;
	logic         res_valid_q;
	logic         step_emit;
	res_item_t    step_res;
	logic         out_free;
	logic         s1_go;

	// parse step logic
	s2i_step u_step (
		.cur         (state_q),
		.item        (char_s1),
		.number_base (base_q),
		.nxt         (state_nxt),
		.emit        (step_emit),
		.result      (step_res)
	);

	// handshake control
	assign out_free   = !res_valid_q || !res_stall;
	assign s1_go      = valid_s1 && (!step_emit || out_free);
	assign char_stall = valid_s1 && !s1_go;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res_item   = res_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '0;
			base_q      <= BASE_AUTO;
			res_valid_q <= 1'b0;
		end else begin
			if (!char_stall) begin
				valid_s1 <= char_valid;
			end
			if (s1_go) begin
				state_q <= state_nxt;
			end
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (s1_go && step_emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_item;
		end
		if (s1_go && step_emit) begin
			res_q <= step_res;
		end
	end

	// a result is only written when the result register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && step_emit) |-> out_free)
		else $error("result register overwritten while held");

	// every result leaves the parse idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && step_emit) |=> (state_q.phase == PH_IDLE))
		else $error("parse not idle after result");

	// a result with no number carries zero value and offset
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.formed || (res_q.value == '0 && res_q.end_offset == '0)))
		else $error("unformed result with nonzero fields");

	// a held character keeps its contents until parsed
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> (valid_s1 && $stable(char_s1)))
		else $error("waiting character lost");

	// the character counter never wraps back to zero inside a parse
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && !char_s1.start_req && state_q.phase != PH_IDLE && state_q.count != '0)
		|=> (state_q.count != '0))
		else $error("character counter wrapped");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench for the streaming string to integer parser
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import s2i_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PER_RADIX = 36;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_HIGH = 8'hFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic char_stall;
	char_item_t char_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_item_t res_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [5:0] cfg_data = '0;

	string_to_integer_parser_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// characters waiting to be sent and numbers waiting to come back
	char_item_t char_backlog[$];
	res_item_t  due_numbers[$];

	int chars_queued = 0;
	int chars_in = 0;
	int junk_items = 0;
	int numbers_seen = 0;
	int radix_writes = 0;
	int errors = 0;
	int quiet_cycles = 0;
	int gap_left = 0;
	int stall_left = 3;
	bit char_calm = 1'b0;
	bit res_calm = 1'b0;
	logic char_taken = 1'b0;
	logic res_taken = 1'b0;

	// parser state as the testbench sees it
	logic [5:0]             radix_now = BASE_AUTO;
	phase_t                 ph = PH_IDLE;
	logic [63:0]            acc = '0;
	logic                   neg_sign = 1'b0;
	logic [5:0]             run_base = '0;
	logic [OFFSET_BITS-1:0] pos = '0;
	logic [OFFSET_BITS-1:0] hex_zero_pos = '0;

	task automatic report(string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	// digit weight of a character, 99 when it is no digit in any radix
	function automatic int digit_val(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LC_A && c <= CH_LC_Z) return int'(c - CH_LC_A) + 10;
		if (c >= CH_UC_A && c <= CH_UC_Z) return int'(c - CH_UC_A) + 10;
		return 99;
	endfunction

	function automatic bit blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [OFFSET_BITS-1:0] bump(logic [OFFSET_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic void close_number(bit ok, logic [OFFSET_BITS-1:0] off);
		res_item_t r;
		r.value = ok ? (neg_sign ? -acc : acc) : '0;
		r.end_offset = ok ? off : '0;
		r.formed = ok;
		due_numbers.push_back(r);
		ph = PH_IDLE;
	endfunction

	// first character after whitespace and sign
	function automatic void take_first(logic [7:0] c, logic [OFFSET_BITS-1:0] idx);
		int d;
		if (c == CH_ZERO && (run_base == BASE_AUTO || run_base == BASE_HEX)) begin
			acc = '0;
			hex_zero_pos = bump(idx);
			ph = PH_ZERO;
		end else begin
			if (run_base == BASE_AUTO) run_base = BASE_DEC;
			d = digit_val(c);
			if (d < int'(run_base)) begin
				acc = 64'(d);
				ph = PH_DIGITS;
			end else begin
				close_number(1'b0, '0);
			end
		end
	endfunction

	// advance the parse by one accepted character
	function automatic void parse_char(char_item_t it);
		logic [OFFSET_BITS-1:0] idx;
		int d;
		if (it.start_req) begin
			ph = PH_LEAD;
			acc = '0;
			neg_sign = 1'b0;
			pos = '0;
			hex_zero_pos = '0;
			run_base = radix_now;
			if (run_base == BASE_ONE || run_base > MAX_RADIX) begin
				close_number(1'b0, '0);
				return;
			end
		end
		if (ph == PH_IDLE) return;
		idx = pos;
		pos = bump(pos);
		d = digit_val(it.ch);
		case (ph)
			PH_LEAD: begin
				if (it.ch == CH_MINUS || it.ch == CH_PLUS) begin
					neg_sign = (it.ch == CH_MINUS);
					ph = PH_SIGNED;
				end else if (!blank(it.ch)) begin
					take_first(it.ch, idx);
				end
			end
			PH_SIGNED: take_first(it.ch, idx);
			PH_ZERO: begin
				if (it.ch == CH_LC_X || it.ch == CH_UC_X) begin
					run_base = BASE_HEX;
					ph = PH_PREFIX;
				end else begin
					if (run_base == BASE_AUTO) run_base = BASE_OCT;
					if (d < int'(run_base)) begin
						acc = 64'(d);
						ph = PH_DIGITS;
					end else begin
						close_number(1'b1, idx);
					end
				end
			end
			PH_PREFIX: begin
				if (d < int'(BASE_HEX)) begin
					acc = 64'(d);
					ph = PH_DIGITS;
				end else begin
					close_number(1'b1, hex_zero_pos);
				end
			end
			PH_DIGITS: begin
				if (d < int'(run_base)) acc = acc * 64'(run_base) + 64'(d);
				else close_number(1'b1, idx);
			end
			default: ph = PH_IDLE;
		endcase
	endfunction

	task automatic check_number(res_item_t got);
		res_item_t want;
		numbers_seen++;
		if (due_numbers.size() == 0) begin
			report($sformatf("unexpected number value=%0d offset=%0d formed=%0b",
				got.value, got.end_offset, got.formed));
		end else begin
			want = due_numbers.pop_front();
			if (got.value !== want.value)
				report($sformatf("value %0d, want %0d", got.value, want.value));
			if (got.end_offset !== want.end_offset)
				report($sformatf("end_offset %0d, want %0d", got.end_offset, want.end_offset));
			if (got.formed !== want.formed)
				report($sformatf("formed %0b, want %0b", got.formed, want.formed));
		end
	endtask

	// sample handshakes, check numbers and track the parse
	always @(posedge clk) begin
		char_taken <= char_valid && !char_stall;
		res_taken <= res_valid && !res_stall;
		if (arst_n) begin
			if (res_valid && !res_stall) check_number(res_item);
			if (char_valid && !char_stall) begin
				parse_char(char_item);
				chars_in++;
			end
			if (cfg_valid && cfg_ready) radix_now = cfg_data;
		end
	end

	// character driver with random gaps between items
	always @(negedge clk) begin
		if (arst_n && !(char_valid && !char_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				char_valid <= 1'b0;
			end else if (char_backlog.size() > 0) begin
				char_item <= char_backlog.pop_front();
				char_valid <= 1'b1;
				if ($urandom_range(0, 39) == 0) char_calm = !char_calm;
				gap_left = char_calm ? 0 : $urandom_range(0, 7);
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls per item
	always @(negedge clk) begin
		if (res_taken) begin
			if ($urandom_range(0, 39) == 0) res_calm = !res_calm;
			stall_left = res_calm ? 0 : $urandom_range(0, 7);
		end
		if (res_valid && stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic put(logic [7:0] c, logic s);
		char_item_t it;
		it.ch = c;
		it.start_req = s;
		char_backlog.push_back(it);
		chars_queued++;
	endtask

	// wait until every character is taken and every number is back
	task automatic wait_drained();
		do @(negedge clk); while (chars_in != chars_queued || due_numbers.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_radix(logic [5:0] b);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= b;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		radix_writes++;
	endtask

	function automatic logic [7:0] digit_char(int v);
		if (v < 10) return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	// one string: mostly well formed, sometimes noise, cut short or broken
	task automatic gen_string(logic [5:0] b);
		int kind, n, i, d, eff;
		logic st;
		kind = $urandom_range(0, 9);
		st = 1'b1;
		if (kind == 9) begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++)
				put(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 7) == 0);
		end else begin
			// leading whitespace and sign
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			for (i = 0; i < n; i++) begin
				put(pick_blank(), st);
				st = 1'b0;
			end
			case ($urandom_range(0, 3))
				1: begin put(CH_PLUS, st); st = 1'b0; end
				2: begin put(CH_MINUS, st); st = 1'b0; end
				default: ;
			endcase
			if (!st && $urandom_range(0, 15) == 0) put(pick_blank(), 1'b0);
			// prefix and effective radix
			eff = (b >= 2 && b <= MAX_RADIX) ? int'(b) : 10;
			if (b == BASE_AUTO) begin
				case ($urandom_range(0, 2))
					0: eff = 10;
					1: begin eff = 8; put(CH_ZERO, st); st = 1'b0; end
					default: begin
						eff = 16;
						put(CH_ZERO, st);
						put($urandom_range(0, 1) ? CH_LC_X : CH_UC_X, 1'b0);
						st = 1'b0;
					end
				endcase
			end else if (b == BASE_HEX && $urandom_range(0, 2) == 0) begin
				put(CH_ZERO, st);
				put($urandom_range(0, 1) ? CH_LC_X : CH_UC_X, 1'b0);
				st = 1'b0;
			end
			// digits, long runs now and then so the value wraps
			n = (kind == 8) ? 0 : ($urandom_range(0, 9) == 0 ? $urandom_range(12, 26) :
				$urandom_range(1, 6));
			for (i = 0; i < n; i++) begin
				d = $urandom_range(0, eff - 1);
				if (i == 0 && b == BASE_AUTO && eff == 10 && d == 0) d = 1;
				put(digit_char(d), st);
				st = 1'b0;
			end
			// terminator, left out when the next start cuts the string
			if (kind != 7 || st) begin
				if ($urandom_range(0, 3) != 0) put(CH_NUL, st);
				else put(8'($urandom_range(0, 255)), st);
			end
		end
		// trailing characters with no start, ignored once the string has ended
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 2);
			for (i = 0; i < n; i++) put(8'($urandom_range(0, 255)), 1'b0);
			junk_items += n;
		end
	endtask

	initial begin
		logic [5:0] radix_plan[$];
		int target;
		radix_plan = '{BASE_AUTO, BASE_HEX, BASE_DEC, 6'd2, MAX_RADIX, BASE_OCT, BASE_ONE,
			6'd63, 6'd37, BASE_AUTO};
		repeat (5) radix_plan.push_back(6'($urandom_range(0, 36)));

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed strings in automatic radix
		write_radix(BASE_AUTO);
		put(CH_UC_A, 1'b0);
		put(CH_ZERO, 1'b1); put(CH_LC_X, 1'b0); put(CH_LC_A + 8'd6, 1'b0);
		put(CH_ZERO, 1'b1); put(CH_ZERO + 8'd8, 1'b0);
		put(CH_MINUS, 1'b1); put(CH_SPACE, 1'b0); put(CH_ZERO + 8'd5, 1'b0);
		put(CH_HIGH, 1'b1);
		put(CH_ZERO + 8'd1, 1'b1); put(CH_ZERO + 8'd2, 1'b0);
		put(CH_ZERO + 8'd7, 1'b1); put(CH_UC_Z, 1'b0);
		put(CH_PLUS, 1'b1); put(CH_ZERO, 1'b0); put(CH_UC_X, 1'b0);
		put(CH_ZERO + 8'd1, 1'b0); put(CH_LC_A + 8'd5, 1'b0); put(CH_NUL, 1'b0);
		put(CH_TAB, 1'b1); put(CH_ZERO + 8'd9, 1'b0); put(CH_NUL, 1'b0);
		wait_drained();

		// random strings under each radix setting
		foreach (radix_plan[k]) begin
			write_radix(radix_plan[k]);
			target = chars_queued - junk_items + PER_RADIX;
			while (chars_queued - junk_items < target) gen_string(radix_plan[k]);
			wait_drained();
		end

		if (due_numbers.size() != 0)
			report($sformatf("%0d numbers never arrived", due_numbers.size()));
		$display("checked %0d numbers from %0d characters over %0d radix writes",
			numbers_seen, chars_in, radix_writes);
		$display("radix 0, 1, 2, 8, 10, 16, 36, 37 and 63 used with random gaps and stalls");
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== string_to_integer_parser_core.f =====
rtl/s2i_pkg.sv
rtl/s2i_step.sv
rtl/string_to_integer_parser_core.sv
dv/tb.sv
